### rtl/core/tftp_rr_pkg.sv
// ---------------------------------------------------------------------------
// tftp_rr_pkg
// Shared types and constants for the tftp read receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package tftp_rr_pkg;

   localparam int BlockSizeDefault = 512;
   localparam logic [15:0] HdrBytes = 16'd4;

   localparam logic [15:0] OpData  = 16'd3;
   localparam logic [15:0] OpError = 16'd5;
   localparam logic [15:0] OpOack  = 16'd6;

   localparam logic ModeStart  = 1'b0;
   localparam logic ModePacket = 1'b1;

   localparam logic CsrBufferLimit = 1'b0;
   localparam logic CsrSizeOnly    = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] opcode;
      logic [15:0] block_number;
      logic [15:0] packet_length;
      logic [15:0] peer_port;
      logic [15:0] local_port;
   } item_type;

   typedef struct packed {
      logic        send_ack;
      logic [15:0] ack_block;
      logic [15:0] ack_src_port;
      logic [15:0] ack_dst_port;
      logic        store_enable;
      logic [31:0] store_offset;
      logic [15:0] store_length;
      logic        in_progress;
      logic        failed;
      logic [31:0] file_size;
      logic        unhandled;
   } result_type;

   typedef struct packed {
      logic [15:0] expected_block;
      logic [31:0] received_bytes;
      logic        running;
      logic        error_flag;
      logic [15:0] tolerated_block;
   } state_type;

   typedef struct packed {
      logic [31:0] buffer_limit;
      logic        size_only;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/core/tftp_rr_step.sv
// ---------------------------------------------------------------------------
// tftp_rr_step
// Per-request transfer logic: next state and result for one request.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_rr_step #(
   parameter int BLOCK_SIZE = tftp_rr_pkg::BlockSizeDefault
) (
   input  tftp_rr_pkg::item_type   item,
   input  tftp_rr_pkg::state_type  cur,
   input  tftp_rr_pkg::cfg_type    cfg,
   output tftp_rr_pkg::state_type  nxt,
   output tftp_rr_pkg::result_type res
);
   import tftp_rr_pkg::*;

   localparam logic [15:0] BlockSizeW = 16'(BLOCK_SIZE);

   logic [15:0] dsz;
   logic [32:0] total;
   logic        over;
   logic [31:0] sat_total;

   assign dsz       = (item.packet_length >= HdrBytes) ? (item.packet_length - HdrBytes) : '0;
   assign total     = {1'b0, cur.received_bytes} + {17'd0, dsz};
   assign over      = !cfg.size_only && (total > {1'b0, cfg.buffer_limit});
   assign sat_total = total[32] ? '1 : total[31:0];

   always_comb begin
      nxt = cur;
      res = '0;
      if (item.mode == ModeStart) begin
         nxt.expected_block = 16'd1;
         nxt.received_bytes = '0;
         nxt.running        = 1'b1;
         nxt.error_flag     = 1'b0;
      end else begin
         case (item.opcode)
            OpData: begin
               if (over) begin
                  nxt.running    = 1'b0;
                  nxt.error_flag = 1'b1;
                  res.send_ack   = 1'b1;
                  res.ack_block  = item.block_number;
               end else if (item.block_number != cur.expected_block) begin
                  if (cur.tolerated_block != item.block_number) begin
                     nxt.running    = 1'b0;
                     nxt.error_flag = 1'b1;
                  end
               end else begin
                  if (!cfg.size_only) begin
                     res.store_enable = 1'b1;
                     res.store_offset = cur.received_bytes;
                     res.store_length = dsz;
                  end
                  nxt.received_bytes  = sat_total;
                  nxt.expected_block  = cur.expected_block + 16'd1;
                  nxt.tolerated_block = cur.expected_block + 16'd1;
                  res.send_ack        = 1'b1;
                  res.ack_block       = item.block_number;
                  if (dsz < BlockSizeW) begin
                     nxt.running = 1'b0;
                  end
               end
            end
            OpError: begin
               nxt.error_flag = 1'b1;
               nxt.running    = 1'b0;
            end
            OpOack: begin
               res.send_ack = 1'b1;
            end
            default: begin
               res.unhandled = 1'b1;
            end
         endcase
      end
      if (res.send_ack) begin
         res.ack_src_port = item.local_port;
         res.ack_dst_port = item.peer_port;
      end
      res.in_progress = nxt.running;
      res.failed      = nxt.error_flag;
      res.file_size   = nxt.received_bytes;
   end

endmodule

`default_nettype wire

### rtl/core/tftp_read_receiver.sv
// ---------------------------------------------------------------------------
// tftp_read_receiver
// Receive side of a tftp read transfer: start and packet-header requests in,
// one acknowledge / store / status response out per request.
//
// The req_ channel takes a start command (mode 0) or a received packet
// header (mode 1). Each request gives exactly one response on the rsp_
// channel, in order. A request is registered in the input register on
// acceptance, runs through the transfer logic and lands in the response
// register, which raises rsp_valid; the response is taken on a clock
// edge at which rsp_valid is high and rsp_stall is low.
// Throughput is one request per cycle; the only limit is the single
// response register, which is loaded as soon as it is empty or being taken.
// When the receiver holds rsp_stall the response is held, one further
// request is kept in the input register and req_stall is raised.
// The csr_ port writes buffer_limit (index 0) and size_only (index 1);
// a write takes effect at once, so write only while no request is in flight.
// Synchronous reset clears both channels, the transfer state and both
// configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_read_receiver #(
   parameter int BLOCK_SIZE = tftp_rr_pkg::BlockSizeDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_opcode,
   input  wire logic [15:0] req_block_number,
   input  wire logic [15:0] req_packet_length,
   input  wire logic [15:0] req_peer_port,
   input  wire logic [15:0] req_local_port,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_send_ack,
   output      logic [15:0] rsp_ack_block,
   output      logic [15:0] rsp_ack_src_port,
   output      logic [15:0] rsp_ack_dst_port,
   output      logic        rsp_store_enable,
   output      logic [31:0] rsp_store_offset,
   output      logic [15:0] rsp_store_length,
   output      logic        rsp_in_progress,
   output      logic        rsp_failed,
   output      logic [31:0] rsp_file_size,
   output      logic        rsp_unhandled,

   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);
   import tftp_rr_pkg::*;

   logic       in_valid_ff;
   item_type   in_ff;
   logic       out_valid_ff;
   result_type out_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type out_in;
   cfg_type    cfg_ff;
   logic       out_load;
   logic       req_take;

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   tftp_rr_step #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_step (
      .item(in_ff),
      .cur (state_ff),
      .cfg (cfg_ff),
      .nxt (state_in),
      .res (out_in)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (out_load) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CsrBufferLimit: cfg_ff.buffer_limit <= csr_write_data;
               CsrSizeOnly:    cfg_ff.size_only    <= csr_write_data[0];
               default:        cfg_ff              <= cfg_ff;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.mode          <= req_mode;
         in_ff.opcode        <= req_opcode;
         in_ff.block_number  <= req_block_number;
         in_ff.packet_length <= req_packet_length;
         in_ff.peer_port     <= req_peer_port;
         in_ff.local_port    <= req_local_port;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_send_ack     = out_ff.send_ack;
   assign rsp_ack_block    = out_ff.ack_block;
   assign rsp_ack_src_port = out_ff.ack_src_port;
   assign rsp_ack_dst_port = out_ff.ack_dst_port;
   assign rsp_store_enable = out_ff.store_enable;
   assign rsp_store_offset = out_ff.store_offset;
   assign rsp_store_length = out_ff.store_length;
   assign rsp_in_progress  = out_ff.in_progress;
   assign rsp_failed       = out_ff.failed;
   assign rsp_file_size    = out_ff.file_size;
   assign rsp_unhandled    = out_ff.unhandled;

   a_stall_from_backpressure : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall raised without response backpressure");

   a_start_status : assert property (@(posedge clock) disable iff (reset)
      (out_load && (in_ff.mode == ModeStart)) |=>
      (rsp_valid && rsp_in_progress && !rsp_failed && (rsp_file_size == '0)))
      else $error("start request gave wrong status");

   a_store_acks : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_enable) |-> rsp_send_ack)
      else $error("store without acknowledgement");

   a_no_ack_ports : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_send_ack) |->
      ((rsp_ack_src_port == '0) && (rsp_ack_dst_port == '0) && (rsp_ack_block == '0)))
      else $error("acknowledge fields set without acknowledgement");

endmodule

`default_nettype wire

### verif/tftp_read_receiver_test.sv
// ---------------------------------------------------------------------------
// tftp_read_receiver_test
// Self-checking bench for the tftp read receiver. A behavioural predictor
// keeps its own transfer state and expected responses. Each request drives
// the predictor, and every response is compared field by field in order.
// The stimulus is a directed opening, then randomised transfers under
// several buffer settings with random gaps and stalls on both channels,
// then a stretch with no gaps or stalls at all, then a last random run.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_read_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tftp_rr_pkg::*;

   class transfer_scoreboard;
      cfg_type    cfg;
      state_type  st;
      result_type expected_responses[$];
      int         errors;

      function new();
         cfg = '0;
         st = '0;
         errors = 0;
      endfunction

      function void write_register(logic index, logic [31:0] data);
         if (index == CsrBufferLimit) cfg.buffer_limit = data;
         else cfg.size_only = data[0];
      endfunction

      function void note_request(item_type it);
         result_type r;
         logic [15:0] payload;
         logic [32:0] total;
         r = '0;
         if (it.mode == ModeStart) begin
            st.expected_block = 16'd1;
            st.received_bytes = '0;
            st.running = 1'b1;
            st.error_flag = 1'b0;
         end else if (it.opcode == OpData) begin
            payload = (it.packet_length >= HdrBytes) ? it.packet_length - HdrBytes : 16'd0;
            total = {1'b0, st.received_bytes} + {17'd0, payload};
            if (!cfg.size_only && total > {1'b0, cfg.buffer_limit}) begin
               st.running = 1'b0;
               st.error_flag = 1'b1;
               r.send_ack = 1'b1;
               r.ack_block = it.block_number;
            end else if (it.block_number != st.expected_block) begin
               if (it.block_number != st.tolerated_block) begin
                  st.running = 1'b0;
                  st.error_flag = 1'b1;
               end
            end else begin
               if (!cfg.size_only) begin
                  r.store_enable = 1'b1;
                  r.store_offset = st.received_bytes;
                  r.store_length = payload;
               end
               st.received_bytes = total[32] ? 32'hFFFF_FFFF : total[31:0];
               st.expected_block = st.expected_block + 16'd1;
               r.send_ack = 1'b1;
               r.ack_block = it.block_number;
               if (int'(payload) < BlockSizeDefault) st.running = 1'b0;
               st.tolerated_block = st.expected_block;
            end
         end else if (it.opcode == OpError) begin
            st.error_flag = 1'b1;
            st.running = 1'b0;
         end else if (it.opcode == OpOack) begin
            r.send_ack = 1'b1;
         end else begin
            r.unhandled = 1'b1;
         end
         if (r.send_ack) begin
            r.ack_src_port = it.local_port;
            r.ack_dst_port = it.peer_port;
         end
         r.in_progress = st.running;
         r.failed = st.error_flag;
         r.file_size = st.received_bytes;
         expected_responses.push_back(r);
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            if (errors < 10)
               $display("mismatch on %s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_responses.size() == 0) begin
            if (errors < 10) $display("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_responses.pop_front();
         check_field("send_ack", 32'(want.send_ack), 32'(got.send_ack));
         check_field("ack_block", 32'(want.ack_block), 32'(got.ack_block));
         check_field("ack_src_port", 32'(want.ack_src_port), 32'(got.ack_src_port));
         check_field("ack_dst_port", 32'(want.ack_dst_port), 32'(got.ack_dst_port));
         check_field("store_enable", 32'(want.store_enable), 32'(got.store_enable));
         check_field("store_offset", want.store_offset, got.store_offset);
         check_field("store_length", 32'(want.store_length), 32'(got.store_length));
         check_field("in_progress", 32'(want.in_progress), 32'(got.in_progress));
         check_field("failed", 32'(want.failed), 32'(got.failed));
         check_field("file_size", want.file_size, got.file_size);
         check_field("unhandled", 32'(want.unhandled), 32'(got.unhandled));
      endfunction

      function void check_drained();
         if (expected_responses.size() != 0) begin
            if (errors < 10)
               $display("%0d responses never arrived", expected_responses.size());
            errors += expected_responses.size();
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [15:0] req_opcode;
   logic [15:0] req_block_number;
   logic [15:0] req_packet_length;
   logic [15:0] req_peer_port;
   logic [15:0] req_local_port;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_send_ack;
   logic [15:0] rsp_ack_block;
   logic [15:0] rsp_ack_src_port;
   logic [15:0] rsp_ack_dst_port;
   logic        rsp_store_enable;
   logic [31:0] rsp_store_offset;
   logic [15:0] rsp_store_length;
   logic        rsp_in_progress;
   logic        rsp_failed;
   logic [31:0] rsp_file_size;
   logic        rsp_unhandled;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   transfer_scoreboard board;
   logic        calm = 1'b0;
   int          requests_sent = 0;
   logic [15:0] tail_block = 16'd0;

   tftp_read_receiver #(.BLOCK_SIZE(BlockSizeDefault)) u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 34);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(item_type'({req_mode, req_opcode, req_block_number,
                                           req_packet_length, req_peer_port,
                                           req_local_port}));
         if (rsp_valid && !rsp_stall)
            board.check_response(result_type'({rsp_send_ack, rsp_ack_block,
                                               rsp_ack_src_port, rsp_ack_dst_port,
                                               rsp_store_enable, rsp_store_offset,
                                               rsp_store_length, rsp_in_progress,
                                               rsp_failed, rsp_file_size,
                                               rsp_unhandled}));
      end
   end

   task automatic send_item(input logic mode, input logic [15:0] opcode,
                            input logic [15:0] block_number,
                            input logic [15:0] packet_length,
                            input logic [15:0] peer_port,
                            input logic [15:0] local_port);
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_opcode <= opcode;
      req_block_number <= block_number;
      req_packet_length <= packet_length;
      req_peer_port <= peer_port;
      req_local_port <= local_port;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic send_packet(input logic [15:0] opcode, input logic [15:0] block_number,
                              input logic [15:0] packet_length);
      send_item(ModePacket, opcode, block_number, packet_length,
                16'($urandom_range(65535)), 16'($urandom_range(65535)));
   endtask

   task automatic send_start();
      send_item(ModeStart, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)));
   endtask

   task automatic write_csr(input logic index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      board.write_register(index, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] limit, input logic count_only);
      write_csr(CsrBufferLimit, limit);
      write_csr(CsrSizeOnly, {31'($urandom), count_only});
   endtask

   // drop valid and let every outstanding response drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] full_length();
      if ($urandom_range(99) < 88) return 16'd516;
      return 16'($urandom_range(65535, 516));
   endfunction

   task automatic play_transfer();
      logic [15:0] blk;
      int          blocks;
      int          roll;
      blk = 16'd1;
      blocks = $urandom_range(6, 1);
      if ($urandom_range(9) != 0) send_start();
      if ($urandom_range(4) == 0) send_packet(OpData, tail_block, full_length());
      if ($urandom_range(3) == 0) send_packet(OpOack, 16'($urandom_range(65535)), 16'd4);
      for (int i = 0; i < blocks; i++) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            send_packet(OpData, 16'($urandom_range(65535)), full_length());
         end else if (roll < 8) begin
            send_packet(OpData, blk - 16'd1, 16'($urandom_range(600)));
         end else if (roll < 10) begin
            send_packet(OpError, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end else if (roll < 12) begin
            send_packet(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)));
         end else if (roll < 14) begin
            send_item(1'($urandom_range(1)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end else begin
            send_packet(OpData, blk,
                        (i == blocks - 1) ? 16'($urandom_range(515)) : full_length());
            blk++;
         end
      end
      tail_block = blk;
   endtask

   task automatic run_phase(input int count);
      int target;
      target = requests_sent + count;
      while (requests_sent < target) play_transfer();
   endtask

   initial begin
      logic [31:0] limits[5];
      logic        count_only[5];

      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= ModeStart;
      req_opcode <= '0;
      req_block_number <= '0;
      req_packet_length <= '0;
      req_peer_port <= '0;
      req_local_port <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CsrBufferLimit;
      csr_write_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(32'd2000, 1'b0);
      // packets before any start
      send_packet(OpData, 16'd1, 16'd516);
      send_packet(OpData, 16'd0, 16'd4);
      send_item(ModePacket, OpOack, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ModeStart, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ModePacket, OpOack, 16'd0, 16'd0, 16'd0, 16'd0);
      // fills the buffer exactly
      send_packet(OpData, 16'd1, 16'd516);
      send_packet(OpData, 16'd2, 16'd516);
      send_packet(OpData, 16'd3, 16'd516);
      send_packet(OpData, 16'd4, 16'd468);
      send_item(ModeStart, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      // duplicate trailing packet, then a short length
      send_packet(OpData, 16'd5, 16'd100);
      send_packet(OpData, 16'd1, 16'd3);
      send_packet(OpData, 16'd1, 16'd516);
      send_start();
      send_packet(OpData, 16'd1, 16'hFFFF);
      send_start();
      send_packet(OpData, 16'd7, 16'd516);
      send_start();
      send_packet(OpError, 16'd1, 16'd9);
      send_packet(16'd0, 16'd1, 16'd516);
      send_packet(16'hFFFF, 16'd1, 16'd516);
      send_packet(16'd4, 16'd1, 16'd516);
      send_packet(16'h8000, 16'd1, 16'd516);
      send_packet(OpData, 16'd1, 16'd2004);
      send_packet(OpData, 16'd2, 16'd5);
      settle();

      limits = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(20000, 600)), 32'd3000,
                 32'($urandom)};
      count_only = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      for (int p = 0; p < 5; p++) begin
         configure(limits[p], count_only[p]);
         run_phase(70);
         // hold off until the pipe is empty
         settle();
         run_phase(75);
         settle();
      end

      // a stretch without gaps or stalls on either side
      configure(32'hFFFF_FFFF, 1'b0);
      calm = 1'b1;
      run_phase(40);
      settle();
      calm = 1'b0;
      send_start();
      run_phase(20);

      settle();
      repeat (8) @(posedge clock);
      board.check_drained();
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

`default_nettype wire
